// File: rtl/core/i4rq_pkg.sv
// shared types, constants and helpers of the int4 group requantizer
`timescale 1ns / 1ps
`default_nettype none

package i4rq_pkg;

    // element and stage counts
    localparam int LANES  = 16;
    localparam int STAGES = 4;

    // field widths
    localparam int CODE_W   = 4;
    localparam int SBYTE_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int PACKED_W = LANES * CODE_W;
    localparam int SCALE_W  = 32;
    localparam int HALF_W   = (LANES / 2) * BYTE_W;
    localparam int DIFF_W   = 5;   // q - zp in -9..9
    localparam int SCL_W    = 7;   // s in 9..72
    localparam int X_W      = 11;  // (q - zp) * s and y in -652..652
    localparam int P_W      = 23;  // y * 3640 plus rounding
    localparam int SHIFT    = 15;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_OUT    = 1'd1;

    // group size range and reset value
    localparam logic [2:0] GROUP_LOG2_MIN   = 3'd2;
    localparam logic [2:0] GROUP_LOG2_MAX   = 3'd4;
    localparam logic [2:0] GROUP_LOG2_RESET = 3'd2;

    // arithmetic constants
    localparam logic [3:0] ZP_BASE    = 4'd6;
    localparam logic [6:0] SCALE_BASE = 7'd9;
    localparam logic signed [X_W-1:0] SIGN_STEP = 11'sd4;
    localparam logic signed [12:0] DIV9_MUL = 13'sd3640;  // 32768 / 9
    localparam logic signed [P_W-1:0] RND_HALF = 23'sd16384;
    localparam logic [BYTE_W-1:0] UNSIGNED_FLIP = 8'h80;

    // stage load enables from pipeline control to the lanes
    typedef struct packed {
        logic [STAGES-1:0] load;
    } i4rq_adv_t;

    // scale byte that serves element e under a clamped group size
    function automatic logic [SBYTE_W-1:0] scale_sel(
        input logic [3:0]         e,
        input logic [2:0]         gl,
        input logic [SCALE_W-1:0] scales
    );
        logic [3:0] g;
        g = e >> gl;
        return scales[8 * g[1:0] +: SBYTE_W];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/i4rq_ctrl.sv
// valid/ready control of the requantizer pipeline with the final mark sideband
`timescale 1ns / 1ps
`default_nettype none

module i4rq_ctrl
    import i4rq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      final_word,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic           final_out,
    output i4rq_adv_t      adv
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] final_reg;
    logic [STAGES-1:0] stage_ready;

    // a stage takes new data when it is empty or its content moves on
    always_comb
    begin
        stage_ready[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    // load enables and next valid bits
    always_comb
    begin
        adv.load[0]   = in_valid && stage_ready[0];
        valid_next[0] = stage_ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            adv.load[k]   = valid_reg[k-1] && stage_ready[k];
            valid_next[k] = stage_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // final mark travels with its transaction
    always_ff @(posedge clk)
    begin
        if (adv.load[0])
        begin
            final_reg[0] <= final_word;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (adv.load[k])
            begin
                final_reg[k] <= final_reg[k-1];
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGES-1];
    assign final_out = final_reg[STAGES-1];

endmodule

`default_nettype wire

// File: rtl/core/i4rq_lane.sv
// four-stage datapath that requantizes one 4-bit code to one output byte
`timescale 1ns / 1ps
`default_nettype none

module i4rq_lane
    import i4rq_pkg::*;
(
    input  wire logic               clk,
    input  wire i4rq_adv_t          adv,
    input  wire logic [CODE_W-1:0]  code,
    input  wire logic [SBYTE_W-1:0] sbyte,
    input  wire logic               unsigned_out,
    output logic [BYTE_W-1:0]       result
);

    logic signed [DIFF_W-1:0] diff_reg;
    logic [SCL_W-1:0]         scl_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [P_W-1:0]    p_reg;
    logic [BYTE_W-1:0]        result_reg;

    logic [3:0]               zp;
    logic signed [DIFF_W-1:0] diff_next;
    logic [SCL_W-1:0]         scl_next;
    logic signed [12:0]       x_full;
    logic signed [X_W-1:0]    y;
    logic signed [23:0]       p_full;
    logic signed [P_W-1:0]    rounded;
    logic [BYTE_W-1:0]        result_next;

    // stage 1: zero point offset and scale from the scale byte
    always_comb
    begin
        zp        = {2'b00, sbyte[7:6]} + ZP_BASE;
        diff_next = $signed({1'b0, code}) - $signed({1'b0, zp});
        scl_next  = {1'b0, sbyte[5:0]} + SCALE_BASE;
    end

    // stage 2: scaled value
    assign x_full = 13'(diff_reg) * $signed({6'b0, scl_reg});

    // stage 3: push away from zero, then multiply by the reciprocal of nine
    always_comb
    begin
        if (x_reg > 0)
        begin
            y = x_reg + SIGN_STEP;
        end
        else if (x_reg < 0)
        begin
            y = x_reg - SIGN_STEP;
        end
        else
        begin
            y = '0;
        end
        p_full = 24'(y) * 24'(DIV9_MUL);
    end

    // stage 4: round, shift and optional unsigned offset
    always_comb
    begin
        rounded     = p_reg + RND_HALF;
        result_next = rounded[P_W-1:SHIFT] ^ (unsigned_out ? UNSIGNED_FLIP : '0);
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (adv.load[0])
        begin
            diff_reg <= diff_next;
            scl_reg  <= scl_next;
        end
        if (adv.load[1])
        begin
            x_reg <= x_full[X_W-1:0];
        end
        if (adv.load[2])
        begin
            p_reg <= p_full[P_W-1:0];
        end
        if (adv.load[3])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/int4_group_requantize_to_int8.sv
// top level of the int4 group requantizer: configuration, scale routing and lanes
`timescale 1ns / 1ps
`default_nettype none

// Turns each 64-bit word of sixteen packed 4-bit codes into sixteen bytes,
// using one scale byte per group of 4, 8 or 16 elements (zero point from bits
// 7..6 plus 6, scale from bits 5..0 plus 9). A new word is taken in every
// cycle unless a full pipeline is held by a low out_ready. Each element passes
// four register stages (operand decode, multiply by the scale, multiply by
// 3640, round and shift) to the output register. Ready back-propagates
// through the stage valid bits, so empty stages are filled even while the
// output stalls. The user must write group_size_log2 and unsigned_out via
// the cfg port only while no transaction is in flight; the block does
// not enforce this. Group sizes outside 4..16 clamp to the nearest end.
module int4_group_requantize_to_int8
    import i4rq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [PACKED_W-1:0]   packed_word,
    input  wire logic [SCALE_W-1:0]    scale_word,
    input  wire logic                  final_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [HALF_W-1:0]          low_bytes,
    output logic [HALF_W-1:0]          high_bytes,
    output logic                       final_out
);

    logic [2:0]               group_log2_reg;
    logic                     unsigned_out_reg;
    logic [2:0]               group_log2_eff;
    i4rq_adv_t                adv;
    logic [2*HALF_W-1:0]      all_bytes;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_log2_reg   <= GROUP_LOG2_RESET;
            unsigned_out_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GROUP_SIZE_LOG2: group_log2_reg   <= cfg_data[2:0];
                REG_UNSIGNED_OUT:    unsigned_out_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // clamp the group size into its supported range
    always_comb
    begin
        if (group_log2_reg < GROUP_LOG2_MIN)
        begin
            group_log2_eff = GROUP_LOG2_MIN;
        end
        else if (group_log2_reg > GROUP_LOG2_MAX)
        begin
            group_log2_eff = GROUP_LOG2_MAX;
        end
        else
        begin
            group_log2_eff = group_log2_reg;
        end
    end

    // handshake and stage enables
    i4rq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .final_word (final_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .final_out  (final_out),
        .adv        (adv)
    );

    // one lane per element
    for (genvar e = 0; e < LANES; e++)
    begin : g_lane
        i4rq_lane u_lane (
            .clk          (clk),
            .adv          (adv),
            .code         (packed_word[CODE_W*e +: CODE_W]),
            .sbyte        (scale_sel(4'(e), group_log2_eff, scale_word)),
            .unsigned_out (unsigned_out_reg),
            .result       (all_bytes[BYTE_W*e +: BYTE_W])
        );
    end

    assign low_bytes  = all_bytes[HALF_W-1:0];
    assign high_bytes = all_bytes[2*HALF_W-1:HALF_W];

endmodule

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench of the int4 group requantizer with random handshake idling
`timescale 1ns / 1ps

module testbench;
    import i4rq_pkg::*;

    // one result of the block: both byte halves and the end-of-vector mark
    typedef struct packed {
        logic [HALF_W-1:0] low;
        logic [HALF_W-1:0] high;
        logic              fin;
    } byte_pair_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [PACKED_W-1:0]   packed_word;
    logic [SCALE_W-1:0]    scale_word;
    logic                  final_word;
    logic                  out_valid;
    logic                  out_ready;
    logic [HALF_W-1:0]     low_bytes;
    logic [HALF_W-1:0]     high_bytes;
    logic                  final_out;

    // predictor copy of the configuration registers
    logic [2:0]            cfg_group_log2;
    logic                  cfg_unsigned;

    // requantized words still owed by the block, oldest first
    byte_pair_t            pending_bytes[$];
    int                    error_count;

    // idle burst odds: one chance in n per transaction, zero turns idling off
    int                    gap_odds;

    // output side stall counter and checker scratch
    int                    stall_count = 0;
    byte_pair_t            chk_expected;
    byte_pair_t            chk_got;

    int4_group_requantize_to_int8 i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .packed_word (packed_word),
        .scale_word  (scale_word),
        .final_word  (final_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .low_bytes   (low_bytes),
        .high_bytes  (high_bytes),
        .final_out   (final_out)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // expected result of one word under the current configuration
    function automatic byte_pair_t predict(
        input logic [PACKED_W-1:0] pw,
        input logic [SCALE_W-1:0]  sw,
        input logic                fw
    );
        byte_pair_t         res;
        int                 gl;
        int                 code;
        int                 g;
        int                 zp;
        int                 sc;
        int                 x;
        int                 y;
        int                 r;
        logic [SBYTE_W-1:0] sb;
        logic [BYTE_W-1:0]  b;
        res = '0;
        gl  = int'(cfg_group_log2);
        if (gl < 2)
        begin
            gl = 2;
        end
        if (gl > 4)
        begin
            gl = 4;
        end
        for (int e = 0; e < LANES; e++)
        begin
            code = int'(pw[CODE_W*e +: CODE_W]);
            g    = (e >> gl) & 3;
            sb   = sw[SBYTE_W*g +: SBYTE_W];
            zp   = int'(sb[7:6]) + 6;
            sc   = int'(sb[5:0]) + 9;
            x    = (code - zp) * sc;
            if (x > 0)
            begin
                y = x + 4;
            end
            else if (x < 0)
            begin
                y = x - 4;
            end
            else
            begin
                y = 0;
            end
            r = (y * 3640 + 16384) >>> 15;
            b = 8'(r);
            if (cfg_unsigned)
            begin
                b = b + 8'd128;
            end
            if (e < 8)
            begin
                res.low[BYTE_W*e +: BYTE_W] = b;
            end
            else
            begin
                res.high[BYTE_W*(e-8) +: BYTE_W] = b;
            end
        end
        res.fin = fw;
        return res;
    endfunction

    // print one mismatch line and count it
    task automatic report_mismatch(
        input string      kind,
        input byte_pair_t exp_item,
        input byte_pair_t got_item
    );
        $display("mismatch (%s) at %0t: expected low %h high %h fin %b, got low %h high %h fin %b",
                 kind, $time, exp_item.low, exp_item.high, exp_item.fin,
                 got_item.low, got_item.high, got_item.fin);
        error_count++;
    endtask

    // one configuration write, only while nothing is in flight
    task automatic write_cfg(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_GROUP_SIZE_LOG2)
        begin
            cfg_group_log2 = val;
        end
        else
        begin
            cfg_unsigned = val[0];
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // send one transaction, with an optional idle burst ahead of it
    task automatic send_item(
        input logic [PACKED_W-1:0] pw,
        input logic [SCALE_W-1:0]  sw,
        input logic                fw
    );
        byte_pair_t exp_item;
        exp_item = predict(pw, sw, fw);
        if (gap_odds > 0 && $urandom_range(gap_odds - 1) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        packed_word <= pw;
        scale_word  <= sw;
        final_word  <= fw;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        pending_bytes.push_back(exp_item);
    endtask

    // random word with random scales and final mark
    task automatic send_random();
        send_item({$urandom, $urandom}, $urandom, 1'($urandom_range(1)));
    endtask

    // stop sending and wait until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    // output ready with random stall bursts
    always @(posedge clk)
    begin
        if (stall_count > 0)
        begin
            stall_count <= stall_count - 1;
            out_ready   <= 1'b0;
        end
        else if (gap_odds > 0 && $urandom_range(gap_odds - 1) == 0)
        begin
            stall_count <= int'($urandom_range(8));
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // compare each output transaction with the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            chk_got = {low_bytes, high_bytes, final_out};
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("unexpected transaction", '0, chk_got);
            end
            else
            begin
                chk_expected = pending_bytes.pop_front();
                if (chk_got !== chk_expected)
                begin
                    report_mismatch("data", chk_expected, chk_got);
                end
            end
        end
    end

    // reset configuration: groups of 4, signed bytes
    task automatic test_reset_defaults();
        repeat (100) send_random();
        drain();
    endtask

    // every group size code, including the clamped ones
    task automatic test_group_sizes();
        for (int gl = 0; gl < 8; gl++)
        begin
            write_cfg(REG_GROUP_SIZE_LOG2, 3'(gl));
            repeat (100) send_random();
            drain();
        end
    endtask

    // unsigned output offset over the legal group sizes
    task automatic test_unsigned_out();
        write_cfg(REG_UNSIGNED_OUT, 3'd1);
        for (int gl = 2; gl < 5; gl++)
        begin
            write_cfg(REG_GROUP_SIZE_LOG2, 3'(gl));
            repeat (100) send_random();
            drain();
        end
    endtask

    // all codes against corner scale bytes
    task automatic test_extremes();
        logic [SBYTE_W-1:0] corner_scales [4];
        corner_scales[0] = 8'h00;
        corner_scales[1] = 8'h3F;
        corner_scales[2] = 8'hC0;
        corner_scales[3] = 8'hFF;
        write_cfg(REG_UNSIGNED_OUT, 3'd0);
        write_cfg(REG_GROUP_SIZE_LOG2, GROUP_LOG2_RESET);
        for (int k = 0; k < 64; k++)
        begin
            send_item({16{k[3:0]}}, {4{corner_scales[k[5:4]]}}, k[0]);
        end
        drain();
    endtask

    // no idling on either side, full rate
    task automatic test_back_to_back();
        write_cfg(REG_UNSIGNED_OUT, 3'd1);
        write_cfg(REG_GROUP_SIZE_LOG2, 3'd3);
        gap_odds = 0;
        repeat (300) send_random();
        drain();
    endtask

    initial
    begin
        error_count    = 0;
        gap_odds       = 4;
        cfg_group_log2 = GROUP_LOG2_RESET;
        cfg_unsigned   = 1'b0;
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        packed_word <= '0;
        scale_word  <= '0;
        final_word  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_group_sizes();
        test_unsigned_out();
        test_extremes();
        test_back_to_back();

        if (error_count == 0)
        begin
            $display("int4_group_requantize_to_int8 regression: pass");
        end
        else
        begin
            $display("int4_group_requantize_to_int8 regression: fail");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("int4_group_requantize_to_int8 regression: fail");
        $finish;
    end

endmodule

// File: dv/testbench_top_placeholder_removed.sv
// unused
`timescale 1ns / 1ps
